// File: rtl/icb_pkg.sv
package icb_pkg;

	// Store sizes; the col and row fields are 7 bits, so these stay fixed
	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int MAX_KERNEL = 7;

	localparam logic [1:0] KIND_COEF  = 2'd0;
	localparam logic [1:0] KIND_PIXEL = 2'd1;
	localparam logic [1:0] KIND_QUERY = 2'd2;

	localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [2:0] REG_KERNEL_WIDTH  = 3'd2;
	localparam logic [2:0] REG_KERNEL_HEIGHT = 3'd3;
	localparam logic [2:0] REG_BORDER_MODE   = 3'd4;

	localparam logic [1:0] BORDER_ZERO   = 2'd0;
	localparam logic [1:0] BORDER_CLAMP  = 2'd1;
	localparam logic [1:0] BORDER_MIRROR = 2'd2;
	localparam logic [1:0] BORDER_WRAP   = 2'd3;

	// Coordinates during a query: -kernel..127+kernel, kept in 16 bits signed
	localparam int CW = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_FOLD,
		ST_READ,
		ST_ACC,
		ST_ROUND,
		ST_OUT
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic start;     // latch query coordinates, clear sum, zero tap counters
		logic map;       // compute raw tap coordinates
		logic fold;      // one fold step of the border mapping
		logic read;      // issue frame and kernel reads
		logic acc;       // multiply-accumulate the read pair
		logic next_tap;  // advance tap counters
		logic round;     // round and saturate the sum
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic fold_done;  // both coordinates are inside the frame, or the tap is skipped as zero
		logic last_tap;   // tap counters at final tap
	} status_t;

endpackage

// File: rtl/icb_ctrl.sv
module icb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              query,
	input  icb_pkg::status_t  status,
	input  logic              out_taken,
	output icb_pkg::cmd_t     cmd,
	output logic              busy,
	output logic              out_valid
);

	icb_pkg::state_t state_q, state_d;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			icb_pkg::ST_IDLE:  if (query) state_d = icb_pkg::ST_MAP;
			icb_pkg::ST_MAP:   state_d = icb_pkg::ST_FOLD;
			icb_pkg::ST_FOLD:  if (status.fold_done) state_d = icb_pkg::ST_READ;
			icb_pkg::ST_READ:  state_d = icb_pkg::ST_ACC;
			icb_pkg::ST_ACC:   state_d = status.last_tap ? icb_pkg::ST_ROUND : icb_pkg::ST_MAP;
			icb_pkg::ST_ROUND: state_d = icb_pkg::ST_OUT;
			icb_pkg::ST_OUT:   if (out_taken) state_d = icb_pkg::ST_IDLE;
			default:           state_d = icb_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			icb_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.start = query;
			end
			icb_pkg::ST_MAP:   cmd.map = 1'b1;
			icb_pkg::ST_FOLD:  cmd.fold = 1'b1;
			icb_pkg::ST_READ:  cmd.read = 1'b1;
			icb_pkg::ST_ACC: begin
				cmd.acc = 1'b1;
				cmd.next_tap = 1'b1;
			end
			icb_pkg::ST_ROUND: cmd.round = 1'b1;
			icb_pkg::ST_OUT:   out_valid = 1'b1;
			default:           busy = 1'b1;
		endcase
	end

endmodule

// File: rtl/icb_datapath.sv
module icb_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  icb_pkg::cmd_t       cmd,
	output icb_pkg::status_t    status,
	input  logic                wr_pixel,
	input  logic                wr_coef,
	input  logic [6:0]          in_col,
	input  logic [6:0]          in_row,
	input  logic signed [15:0]  in_value,
	input  logic [7:0]          image_width,
	input  logic [7:0]          image_height,
	input  logic [2:0]          kernel_width,
	input  logic [2:0]          kernel_height,
	input  logic [1:0]          border_mode,
	output logic signed [15:0]  result_value,
	output logic                saturated
);

	localparam int MAX_WIDTH  = icb_pkg::MAX_WIDTH;
	localparam int MAX_HEIGHT = icb_pkg::MAX_HEIGHT;
	localparam int MAX_KERNEL = icb_pkg::MAX_KERNEL;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int KW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
	localparam int KA = (MAX_KERNEL * MAX_KERNEL > 1) ? $clog2(MAX_KERNEL * MAX_KERNEL) : 1;
	localparam int CW = icb_pkg::CW;

	logic signed [15:0] frame_mem [MAX_WIDTH * MAX_HEIGHT];
	logic signed [15:0] kern_mem [MAX_KERNEL * MAX_KERNEL];

	logic signed [CW-1:0] w_eff, h_eff;
	logic [3:0] kw_eff, kh_eff;
	logic [3:0] kx_q, ky_q;
	logic [6:0] qcol_q, qrow_q;
	logic signed [CW-1:0] cx_q, cy_q;
	logic skip_q;
	logic signed [15:0] pix_q, coef_q;
	logic use_q;
	logic signed [47:0] sum_q;

	// Effective sizes
	always_comb begin
		w_eff = (image_width == 8'd0) ? CW'(1) :
			((32'(image_width) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(image_width));
		h_eff = (image_height == 8'd0) ? CW'(1) :
			((32'(image_height) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(image_height));
		kw_eff = (kernel_width == 3'd0) ? 4'd1 :
			((32'(kernel_width) > MAX_KERNEL) ? 4'(MAX_KERNEL) : {1'b0, kernel_width});
		kh_eff = (kernel_height == 3'd0) ? 4'd1 :
			((32'(kernel_height) > MAX_KERNEL) ? 4'(MAX_KERNEL) : {1'b0, kernel_height});
	end

	// One fold step per coordinate: bring a coordinate one period closer to the frame
	function automatic logic signed [CW-1:0] fold1(input logic signed [CW-1:0] c,
			input logic signed [CW-1:0] n, input logic [1:0] mode);
		logic signed [CW-1:0] p;
		p = (n - CW'(1)) <<< 1;
		fold1 = c;
		if (c >= 0 && c < n) begin
			fold1 = c;
		end else begin
			case (mode)
				icb_pkg::BORDER_CLAMP: fold1 = (c < 0) ? CW'(0) : n - CW'(1);
				icb_pkg::BORDER_MIRROR: begin
					if (n == CW'(1)) fold1 = CW'(0);
					else if (c < 0) fold1 = -c;
					else fold1 = p - c;
				end
				icb_pkg::BORDER_WRAP: fold1 = (c < 0) ? c + n : c - n;
				default: fold1 = c;
			endcase
		end
	endfunction

	logic x_in, y_in;
	assign x_in = (cx_q >= 0) && (cx_q < w_eff);
	assign y_in = (cy_q >= 0) && (cy_q < h_eff);
	assign status.fold_done = skip_q || (x_in && y_in);
	assign status.last_tap = (kx_q == kw_eff - 4'd1) && (ky_q == kh_eff - 4'd1);

	// Query control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_q <= '0;
			ky_q <= '0;
			skip_q <= 1'b0;
			use_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				kx_q <= '0;
				ky_q <= '0;
			end else if (cmd.next_tap) begin
				if (kx_q == kw_eff - 4'd1) begin
					kx_q <= '0;
					ky_q <= ky_q + 4'd1;
				end else begin
					kx_q <= kx_q + 4'd1;
				end
			end
			if (cmd.map) skip_q <= 1'b0;
			else if (cmd.fold && (!x_in || !y_in) && border_mode == icb_pkg::BORDER_ZERO)
				skip_q <= 1'b1;
			if (cmd.read) use_q <= !skip_q;
		end
	end

	// Coordinates and sum
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qcol_q <= in_col;
			qrow_q <= in_row;
			sum_q <= '0;
		end
		if (cmd.map) begin
			cx_q <= CW'({1'b0, kw_eff[3:1]}) + CW'(qcol_q) - CW'(kx_q);
			cy_q <= CW'({1'b0, kh_eff[3:1]}) + CW'(qrow_q) - CW'(ky_q);
		end else if (cmd.fold && !skip_q) begin
			cx_q <= fold1(cx_q, w_eff, border_mode);
			cy_q <= fold1(cy_q, h_eff, border_mode);
		end
		if (cmd.acc && use_q) sum_q <= sum_q + 48'(pix_q * coef_q);
	end

	// Frame memory, addressed {row, col}
	always_ff @(posedge clk) begin
		if (wr_pixel && 32'(in_col) < MAX_WIDTH && 32'(in_row) < MAX_HEIGHT)
			frame_mem[{in_row[YW-1:0], in_col[XW-1:0]}] <= in_value;
		if (cmd.read)
			pix_q <= frame_mem[{cy_q[YW-1:0], cx_q[XW-1:0]}];
	end

	// Kernel memory
	always_ff @(posedge clk) begin
		if (wr_coef && 32'(in_col) < MAX_KERNEL && 32'(in_row) < MAX_KERNEL)
			kern_mem[KA'(32'(in_row) * MAX_KERNEL + 32'(in_col))] <= in_value;
		if (cmd.read)
			coef_q <= kern_mem[KA'(32'(ky_q[KW-1:0]) * MAX_KERNEL + 32'(kx_q[KW-1:0]))];
	end

	// Round half up, saturate
	logic signed [47:0] rnd;
	assign rnd = (sum_q + 48'sd2048) >>> 12;
	always_ff @(posedge clk) begin
		if (cmd.round) begin
			if (rnd > 48'sd32767) begin
				result_value <= 16'sd32767;
				saturated <= 1'b1;
			end else if (rnd < -48'sd32768) begin
				result_value <= -16'sd32768;
				saturated <= 1'b1;
			end else begin
				result_value <= rnd[15:0];
				saturated <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/image_convolution_with_borders.sv
// Channel   | Direction | Payload
// s_axis    | in        | tdata: col[6:0] row[13:7] value[29:14]; tuser: kind
// m_axis    | out       | tdata: result_value[15:0]; tuser: saturated
// cfg       | in        | cfg_index, cfg_data
// Writes of pixels and coefficients give no result.
// A query steps through map, fold check, memory read and multiply-accumulate for each
// tap, plus any extra fold steps, then rounds and outputs the result.
// A tap outside the frame adds a fold step in zero and clamp modes; mirror and
// wrap far outside need a fold step per period crossed.
// Reset clears control only; frame and kernel memories hold garbage until written.
// The result stays on m_axis until taken; no new item is accepted meanwhile.
module image_convolution_with_borders (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // col[6:0], row[13:7], value[29:14], zero
	input  logic [1:0]  s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // result_value[15:0]
	output logic        m_axis_tuser,   // saturated
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	icb_pkg::cmd_t    cmd;
	icb_pkg::status_t status;
	logic busy, acc_in;
	logic [7:0] iw_q, ih_q;
	logic [2:0] kw_q, kh_q;
	logic [1:0] bm_q;
	logic signed [15:0] res;

	assign s_axis_tready = !busy;
	assign acc_in = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q <= 8'd128;
			ih_q <= 8'd128;
			kw_q <= 3'd3;
			kh_q <= 3'd3;
			bm_q <= icb_pkg::BORDER_ZERO;
		end else if (cfg_valid) begin
			case (cfg_index)
				icb_pkg::REG_IMAGE_WIDTH:   iw_q <= cfg_data;
				icb_pkg::REG_IMAGE_HEIGHT:  ih_q <= cfg_data;
				icb_pkg::REG_KERNEL_WIDTH:  kw_q <= cfg_data[2:0];
				icb_pkg::REG_KERNEL_HEIGHT: kh_q <= cfg_data[2:0];
				icb_pkg::REG_BORDER_MODE:   bm_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	icb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (acc_in && s_axis_tuser == icb_pkg::KIND_QUERY),
		.status    (status),
		.out_taken (m_axis_tready),
		.cmd       (cmd),
		.busy      (busy),
		.out_valid (m_axis_tvalid)
	);

	icb_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.wr_pixel      (acc_in && s_axis_tuser == icb_pkg::KIND_PIXEL),
		.wr_coef       (acc_in && s_axis_tuser == icb_pkg::KIND_COEF),
		.in_col        (s_axis_tdata[6:0]),
		.in_row        (s_axis_tdata[13:7]),
		.in_value      (s_axis_tdata[29:14]),
		.image_width   (iw_q),
		.image_height  (ih_q),
		.kernel_width  (kw_q),
		.kernel_height (kh_q),
		.border_mode   (bm_q),
		.result_value  (res),
		.saturated     (m_axis_tuser)
	);

	assign m_axis_tdata = res;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int FRAME_W  = 128;
	localparam int FRAME_H  = 128;
	localparam int KSIZE    = 7;
	localparam int FILL     = 16;
	localparam int STALL_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]         kind;
		logic [6:0]         col;
		logic [6:0]         row;
		logic signed [15:0] value;
	} px_item_t;

	typedef struct packed {
		logic signed [15:0] value;
		logic               sat;
	} conv_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	image_convolution_with_borders u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the block's registers and memories
	logic [7:0]         img_w_reg, img_h_reg;
	logic [2:0]         ker_w_reg, ker_h_reg;
	logic [1:0]         border_reg;
	logic signed [15:0] frame_mem [FRAME_W*FRAME_H];
	logic signed [15:0] coef_mem [KSIZE*KSIZE];
	// Pixels already queued for writing, by frame address
	bit                 frame_known [FRAME_W*FRAME_H];

	px_item_t  pending_items[$];
	px_item_t  cur_item;
	conv_out_t expected_pixels[$];
	int        errors;
	bit        burst_mode;
	int        quiet_cycles;

	always #5 clk = ~clk;

	function automatic int clip_dim(input int r, input int maxv);
		if (r == 0) return 1;
		if (r > maxv) return maxv;
		return r;
	endfunction

	// Fold a coordinate into 0..n-1 by the border mode; 0 when it reads as zero
	function automatic bit fold_coord(input int c, input int n, output int o);
		int p, m;
		o = c;
		if (c >= 0 && c < n) return 1;
		case (border_reg)
			icb_pkg::BORDER_ZERO: return 0;
			icb_pkg::BORDER_CLAMP: begin
				o = (c < 0) ? 0 : n - 1;
				return 1;
			end
			icb_pkg::BORDER_MIRROR: begin
				if (n == 1) begin
					o = 0;
					return 1;
				end
				p = 2 * (n - 1);
				m = c % p;
				if (m < 0) m += p;
				if (m >= n) m = p - m;
				o = m;
				return 1;
			end
			default: begin
				m = c % n;
				if (m < 0) m += n;
				o = m;
				return 1;
			end
		endcase
	endfunction

	function automatic conv_out_t convolve_at(input int x, input int y);
		int w, h, kw, kh, px, py;
		longint acc, r;
		conv_out_t o;
		w = clip_dim(img_w_reg, FRAME_W);
		h = clip_dim(img_h_reg, FRAME_H);
		kw = clip_dim(ker_w_reg, KSIZE);
		kh = clip_dim(ker_h_reg, KSIZE);
		acc = 0;
		for (int ky = 0; ky < kh; ky++)
			for (int kx = 0; kx < kw; kx++) begin
				if (!fold_coord(kw / 2 + x - kx, w, px)) continue;
				if (!fold_coord(kh / 2 + y - ky, h, py)) continue;
				acc += longint'(coef_mem[ky*KSIZE+kx]) * longint'(frame_mem[py*FRAME_W+px]);
			end
		// round half up, then saturate
		r = (acc + 2048) >>> 12;
		o.sat = 1'b0;
		if (r > 32767) begin
			r = 32767;
			o.sat = 1'b1;
		end else if (r < -32768) begin
			r = -32768;
			o.sat = 1'b1;
		end
		o.value = r[15:0];
		return o;
	endfunction

	// True when every tap of a query at (x, y) reads a pixel queued before it
	function automatic bit taps_written(input int x, input int y);
		int w, h, kw, kh, px, py;
		w = clip_dim(img_w_reg, FRAME_W);
		h = clip_dim(img_h_reg, FRAME_H);
		kw = clip_dim(ker_w_reg, KSIZE);
		kh = clip_dim(ker_h_reg, KSIZE);
		for (int ky = 0; ky < kh; ky++)
			for (int kx = 0; kx < kw; kx++) begin
				if (!fold_coord(kw / 2 + x - kx, w, px)) continue;
				if (!fold_coord(kh / 2 + y - ky, h, py)) continue;
				if (!frame_known[py*FRAME_W+px]) return 0;
			end
		return 1;
	endfunction

	function automatic void apply_item(input px_item_t it);
		case (it.kind)
			icb_pkg::KIND_COEF:
				if (it.col < KSIZE && it.row < KSIZE)
					coef_mem[it.row*KSIZE+it.col] = it.value;
			icb_pkg::KIND_PIXEL: frame_mem[it.row*FRAME_W+it.col] = it.value;
			icb_pkg::KIND_QUERY: expected_pixels.push_back(convolve_at(it.col, it.row));
			default: ;
		endcase
	endfunction

	// Driver: feed pending items, idling at random unless in a burst
	always @(posedge clk or negedge arst_n) begin
		bit take;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			take = 0;
			if (s_axis_tvalid && s_axis_tready) begin
				apply_item(cur_item);
				take = 1;
			end
			if (!s_axis_tvalid || take) begin
				if (pending_items.size() > 0 &&
					(burst_mode || $urandom_range(99) >= 33)) begin
					cur_item = pending_items.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {2'b00, cur_item.value, cur_item.row, cur_item.col};
					s_axis_tuser  <= cur_item.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, check each result transfer
	always @(posedge clk or negedge arst_n) begin
		conv_out_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_pixels.size() == 0) begin
					$display("%0t: unexpected result value=%h sat=%b",
						$time, m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					if (m_axis_tdata !== want.value) begin
						$display("%0t: result_value expected %h actual %h",
							$time, want.value, m_axis_tdata);
						errors++;
					end
					if (m_axis_tuser !== want.sat) begin
						$display("%0t: saturated expected %b actual %b",
							$time, want.sat, m_axis_tuser);
						errors++;
					end
				end
			end
			m_axis_tready <= burst_mode || ($urandom_range(99) >= 33);
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("image_convolution_with_borders test failed");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] k, input int c, input int r, input int v);
		px_item_t it;
		it.kind = k;
		it.col = c[6:0];
		it.row = r[6:0];
		it.value = v[15:0];
		if (k == icb_pkg::KIND_PIXEL)
			frame_known[int'(it.row)*FRAME_W + int'(it.col)] = 1'b1;
		pending_items.push_back(it);
	endtask

	// Hold until the block is drained, then let any write finish
	task automatic wait_drained();
		wait (pending_items.size() == 0 && !s_axis_tvalid && expected_pixels.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			icb_pkg::REG_IMAGE_WIDTH:   img_w_reg = data;
			icb_pkg::REG_IMAGE_HEIGHT:  img_h_reg = data;
			icb_pkg::REG_KERNEL_WIDTH:  ker_w_reg = data[2:0];
			icb_pkg::REG_KERNEL_HEIGHT: ker_h_reg = data[2:0];
			default:                    border_reg = data[1:0];
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_geometry(input int w, input int h, input int kw, input int kh,
		input logic [1:0] bm);
		write_reg(icb_pkg::REG_IMAGE_WIDTH, w[7:0]);
		write_reg(icb_pkg::REG_IMAGE_HEIGHT, h[7:0]);
		write_reg(icb_pkg::REG_KERNEL_WIDTH, kw[7:0]);
		write_reg(icb_pkg::REG_KERNEL_HEIGHT, kh[7:0]);
		write_reg(icb_pkg::REG_BORDER_MODE, {6'd0, bm});
	endtask

	function automatic int rand_value();
		if ($urandom_range(3) == 0)
			return $urandom_range(65535);
		return int'($urandom_range(8191)) - 4096;
	endfunction

	// Random mix: mostly queries and writes, a few ignored kinds.
	// A query goes out only when all its taps hit pixels already written.
	task automatic queue_random(input int n);
		int sel, qx, qy, lim;
		bit found;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 45) begin
				found = 0;
				qx = 0;
				qy = 0;
				for (int t = 0; t < 30 && !found; t++) begin
					lim = ($urandom_range(1) == 0) ? FILL + 3 : 127;
					qx = $urandom_range(lim);
					qy = $urandom_range(lim);
					found = taps_written(qx, qy);
				end
				if (found)
					push_item(icb_pkg::KIND_QUERY, qx, qy, $urandom_range(65535));
				else
					push_item(icb_pkg::KIND_PIXEL, $urandom_range(FILL - 1),
						$urandom_range(FILL - 1), rand_value());
			end else if (sel < 75)
				push_item(icb_pkg::KIND_PIXEL, $urandom_range(127), $urandom_range(127),
					rand_value());
			else if (sel < 95)
				push_item(icb_pkg::KIND_COEF, $urandom_range(9), $urandom_range(9),
					rand_value());
			else
				push_item(2'd3, $urandom_range(127), $urandom_range(127),
					$urandom_range(65535));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		burst_mode = 1'b1;
		img_w_reg = 8'd128;
		img_h_reg = 8'd128;
		ker_w_reg = 3'd3;
		ker_h_reg = 3'd3;
		border_reg = icb_pkg::BORDER_ZERO;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill every coefficient, a corner block and the far corner of the frame
		for (int r = 0; r < KSIZE; r++)
			for (int c = 0; c < KSIZE; c++)
				push_item(icb_pkg::KIND_COEF, c, r, int'($urandom_range(4095)) - 2048);
		for (int r = 0; r < FILL; r++)
			for (int c = 0; c < FILL; c++)
				push_item(icb_pkg::KIND_PIXEL, c, r, rand_value());
		for (int r = FRAME_H - 4; r < FRAME_H; r++)
			for (int c = FRAME_W - 4; c < FRAME_W; c++)
				push_item(icb_pkg::KIND_PIXEL, c, r, rand_value());
		// Field extremes and queries under the reset settings
		push_item(icb_pkg::KIND_PIXEL, 0, 0, 32'h7fff);
		push_item(icb_pkg::KIND_PIXEL, 127, 127, 32'h8000);
		push_item(icb_pkg::KIND_COEF, 6, 6, 32'h7fff);
		push_item(icb_pkg::KIND_COEF, 7, 7, 32'h1234);
		push_item(2'd3, 127, 127, 32'hffff);
		push_item(icb_pkg::KIND_QUERY, 0, 0, 0);
		push_item(icb_pkg::KIND_QUERY, 127, 127, 32'hffff);
		push_item(icb_pkg::KIND_QUERY, 12, 1, 0);
		wait_drained();
		burst_mode = 1'b0;

		// Saturation both ways with a full kernel
		set_geometry(128, 128, 7, 7, icb_pkg::BORDER_CLAMP);
		for (int r = 0; r < KSIZE; r++)
			for (int c = 0; c < KSIZE; c++)
				push_item(icb_pkg::KIND_COEF, c, r, 32'h7fff);
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				push_item(icb_pkg::KIND_PIXEL, c, r, 32'h8000);
				push_item(icb_pkg::KIND_PIXEL, FRAME_W - 4 + c, FRAME_H - 4 + r, 32'h7fff);
			end
		push_item(icb_pkg::KIND_QUERY, 0, 0, 0);
		push_item(icb_pkg::KIND_QUERY, 127, 127, 0);
		push_item(icb_pkg::KIND_COEF, 3, 3, 32'h8000);
		push_item(icb_pkg::KIND_QUERY, 3, 3, 0);
		wait_drained();

		// Settings sweep: extremes first, then random ones
		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: set_geometry(1, 1, 7, 7, icb_pkg::BORDER_MIRROR);
				1: set_geometry(1, 1, 1, 1, icb_pkg::BORDER_WRAP);
				2: set_geometry(128, 128, 7, 7, icb_pkg::BORDER_WRAP);
				3: set_geometry(128, 128, 1, 7, icb_pkg::BORDER_ZERO);
				4: set_geometry(2, 3, 7, 1, icb_pkg::BORDER_MIRROR);
				5: set_geometry(5, 128, 4, 6, icb_pkg::BORDER_CLAMP);
				default: set_geometry($urandom_range(1, 128), $urandom_range(1, 128),
					$urandom_range(1, 7), $urandom_range(1, 7), 2'($urandom_range(3)));
			endcase
			burst_mode = (ph == 6);
			queue_random(65);
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("image_convolution_with_borders test passed");
		else
			$display("image_convolution_with_borders test failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/icb_pkg.sv
rtl/icb_ctrl.sv
rtl/icb_datapath.sv
rtl/image_convolution_with_borders.sv
bench/tb.sv
